// ----- hw/rtl/bdq_pkg.sv -----
package bdq_pkg;

  localparam int CAPACITY    = 32;
  localparam int NAME_BYTES  = 30;
  localparam int ENTRY_BYTES = 30;
  localparam int ENTRY_W     = 8 * ENTRY_BYTES;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [2:0] OP_POP_BACK   = 3'd2;
  localparam logic [2:0] OP_POP_FRONT  = 3'd3;
  localparam logic [2:0] OP_SHOW       = 3'd4;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]  operation;
    logic [63:0] name_bytes_0_7;
    logic [63:0] name_bytes_8_15;
    logic [63:0] name_bytes_16_23;
    logic [47:0] name_bytes_24_29;
  } req_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [63:0]      out_bytes_0_7;
    logic [63:0]      out_bytes_8_15;
    logic [63:0]      out_bytes_16_23;
    logic [47:0]      out_bytes_24_29;
    logic [CNT_W-1:0] entry_count;
    logic             last;
  } rsp_item_t;

  // Byte 0 sits in the low bits of the flattened entry.
  typedef struct packed {
    logic [47:0] b24_29;
    logic [63:0] b16_23;
    logic [63:0] b8_15;
    logic [63:0] b0_7;
  } entry_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH_BACK,
    CELL_PUSH_FRONT,
    CELL_SHIFT,
    CELL_ROTATE
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t        cmd;
    logic [CNT_W-1:0] count;
  } chain_ctl_t;

  // A name ends at its first nul byte; that byte and all after it read as zero.
  function automatic entry_t normalize_name(input req_item_t item);
    logic [ENTRY_W-1:0] raw;
    logic [ENTRY_W-1:0] res;
    logic               keep;
    raw  = {item.name_bytes_24_29, item.name_bytes_16_23,
            item.name_bytes_8_15, item.name_bytes_0_7};
    res  = '0;
    keep = 1'b1;
    for (int i = 0; i < ENTRY_BYTES; i++) begin
      keep = keep && (raw[8*i +: 8] != 8'd0) && (i < NAME_BYTES);
      if (keep) begin
        res[8*i +: 8] = raw[8*i +: 8];
      end
    end
    return entry_t'(res);
  endfunction

endpackage

// ----- hw/rtl/bdq_cell.sv -----
module bdq_cell (
  input  logic                    clk,
  input  logic [bdq_pkg::IDX_W-1:0] idx,
  input  bdq_pkg::chain_ctl_t     ctl,
  input  bdq_pkg::entry_t         new_entry,
  input  bdq_pkg::entry_t         left_entry,
  input  bdq_pkg::entry_t         right_entry,
  input  bdq_pkg::entry_t         head_entry,
  output bdq_pkg::entry_t         entry
);

  logic [bdq_pkg::CNT_W-1:0] pos;
  logic                      at_back;
  logic                      at_tail;

  assign pos     = bdq_pkg::CNT_W'(idx);
  assign at_back = (pos == ctl.count);
  assign at_tail = (pos + bdq_pkg::CNT_W'(1) == ctl.count);

  always_ff @(posedge clk) begin
    case (ctl.cmd)
      bdq_pkg::CELL_HOLD: begin
      end
      bdq_pkg::CELL_PUSH_BACK: begin
        if (at_back) begin
          entry <= new_entry;
        end
      end
      bdq_pkg::CELL_PUSH_FRONT: begin
        entry <= (pos == '0) ? new_entry : left_entry;
      end
      bdq_pkg::CELL_SHIFT: begin
        entry <= right_entry;
      end
      bdq_pkg::CELL_ROTATE: begin
        entry <= at_tail ? head_entry : right_entry;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hw/rtl/bounded_deque_of_names_unit.sv -----
// Channel  Direction  Handshake               Payload
// req      in         req_valid / req_ready   bdq_pkg::req_item_t
// rsp      out        rsp_valid / rsp_ready   bdq_pkg::rsp_item_t
//
// A push or pop gives one response transfer; with the
// response taken at once, a new request is accepted every cycle.
// A show with N entries held gives N responses: the cycle that accepts it
// gives no response, then one response follows per cycle, as the chain of
// cells rotates its first N cells by one position each cycle.
// Reset empties the queue at once; the entry cells themselves are not cleared.
// A stalled response holds the unit: no request is accepted and the show
// rotation pauses until the waiting response is taken.
module bounded_deque_of_names_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  bdq_pkg::req_item_t  req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output bdq_pkg::rsp_item_t  rsp
);

  typedef enum logic {ST_IDLE, ST_SHOW} state_t;

  state_t                      state, state_next;
  logic [bdq_pkg::CNT_W-1:0]   count, count_next;
  logic [bdq_pkg::IDX_W-1:0]   show_idx, show_idx_next;
  bdq_pkg::rsp_item_t          rsp_next;
  logic                        rsp_load;

  logic                        slot_free;
  logic                        accept;
  logic                        show_step;
  logic                        show_last;
  logic                        is_full;
  logic                        is_empty;
  bdq_pkg::chain_ctl_t         ctl;
  bdq_pkg::entry_t             new_entry;
  bdq_pkg::entry_t             cells [bdq_pkg::CAPACITY];

  // The output register frees up when it is empty or its transfer happens now.
  assign slot_free = !rsp_valid || rsp_ready;
  assign req_ready = (state == ST_IDLE) && slot_free;
  assign accept    = req_valid && req_ready;
  assign show_step = (state == ST_SHOW) && slot_free;
  assign show_last = (bdq_pkg::CNT_W'(show_idx) + bdq_pkg::CNT_W'(1) == count);
  assign is_full   = (count == bdq_pkg::CNT_W'(bdq_pkg::CAPACITY));
  assign is_empty  = (count == '0);
  assign new_entry = bdq_pkg::normalize_name(req);

  // Commands to the chain. Outside a show, cell 0 holds the front entry, so a pop at
  // the back only needs the count to drop, and a pop at the front shifts the
  // whole row toward cell 0.
  always_comb begin
    ctl.count = count;
    ctl.cmd   = bdq_pkg::CELL_HOLD;
    if (accept) begin
      case (req.operation)
        bdq_pkg::OP_PUSH_BACK: begin
          if (!is_full) ctl.cmd = bdq_pkg::CELL_PUSH_BACK;
        end
        bdq_pkg::OP_PUSH_FRONT: begin
          if (!is_full) ctl.cmd = bdq_pkg::CELL_PUSH_FRONT;
        end
        bdq_pkg::OP_POP_FRONT: begin
          if (!is_empty) ctl.cmd = bdq_pkg::CELL_SHIFT;
        end
        default: begin
        end
      endcase
    end else if (show_step) begin
      ctl.cmd = bdq_pkg::CELL_ROTATE;
    end
  end

  // The row of cells. The cell at the back of the ring takes the front entry
  // during a show, so after N steps the order is as it was.
  for (genvar g = 0; g < bdq_pkg::CAPACITY; g++) begin : g_cell
    bdq_pkg::entry_t left_entry;
    bdq_pkg::entry_t right_entry;
    if (g == 0) begin : g_first
      assign left_entry = new_entry;
    end else begin : g_inner_left
      assign left_entry = cells[g-1];
    end
    if (g == bdq_pkg::CAPACITY - 1) begin : g_last
      assign right_entry = cells[0];
    end else begin : g_inner_right
      assign right_entry = cells[g+1];
    end
    bdq_cell u_cell (
      .clk         (clk),
      .idx         (bdq_pkg::IDX_W'(g)),
      .ctl         (ctl),
      .new_entry   (new_entry),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .head_entry  (cells[0]),
      .entry       (cells[g])
    );
  end

  // Next response, count and state.
  always_comb begin
    state_next    = state;
    count_next    = count;
    show_idx_next = show_idx;
    rsp_load      = 1'b0;
    rsp_next      = '0;
    rsp_next.status = bdq_pkg::STATUS_OK;
    rsp_next.last   = 1'b1;
    if (accept) begin
      rsp_load = 1'b1;
      case (req.operation)
        bdq_pkg::OP_PUSH_BACK, bdq_pkg::OP_PUSH_FRONT: begin
          if (is_full) begin
            rsp_next.status = bdq_pkg::STATUS_FULL;
          end else begin
            count_next = count + bdq_pkg::CNT_W'(1);
          end
        end
        bdq_pkg::OP_POP_BACK, bdq_pkg::OP_POP_FRONT: begin
          if (is_empty) begin
            rsp_next.status = bdq_pkg::STATUS_EMPTY;
          end else begin
            count_next = count - bdq_pkg::CNT_W'(1);
          end
        end
        bdq_pkg::OP_SHOW: begin
          if (is_empty) begin
            rsp_next.status = bdq_pkg::STATUS_EMPTY;
          end else begin
            rsp_load      = 1'b0;
            state_next    = ST_SHOW;
            show_idx_next = '0;
          end
        end
        default: begin
        end
      endcase
    end else if (show_step) begin
      rsp_load                 = 1'b1;
      rsp_next.out_bytes_0_7   = cells[0].b0_7;
      rsp_next.out_bytes_8_15  = cells[0].b8_15;
      rsp_next.out_bytes_16_23 = cells[0].b16_23;
      rsp_next.out_bytes_24_29 = cells[0].b24_29;
      rsp_next.last            = show_last;
      show_idx_next            = show_idx + bdq_pkg::IDX_W'(1);
      if (show_last) begin
        state_next = ST_IDLE;
      end
    end
    rsp_next.entry_count = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      show_idx  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      show_idx <= show_idx_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  // The count never passes the capacity.
  assert property (@(posedge clk) disable iff (rst)
    count <= bdq_pkg::CNT_W'(bdq_pkg::CAPACITY))
    else $error("entry count above capacity");

  // A show is only in progress with at least one entry held.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHOW) |-> (count != '0))
    else $error("show running on an empty queue");

  // An accepted push with room left adds exactly one entry.
  assert property (@(posedge clk) disable iff (rst)
    (accept && !is_full && (req.operation == bdq_pkg::OP_PUSH_BACK ||
     req.operation == bdq_pkg::OP_PUSH_FRONT)) |=> (count == $past(count) + 1'b1))
    else $error("push did not add one entry");

  // The final show response returns the unit to idle.
  assert property (@(posedge clk) disable iff (rst)
    (show_step && show_last) |=> (state == ST_IDLE && rsp_valid && rsp.last))
    else $error("show did not end on its last response");

  // The count does not change while a show is in progress.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHOW) |=> $stable(count))
    else $error("count changed during show");

endmodule
